/* rtl/dss_pkg.sv */
// ----------------------------------------------------------------------------
// dss_pkg: shared types and constants for the dry spell statistics block
// Field widths of the per-pixel entry, the request opcodes and the request
// into the divider.
// ----------------------------------------------------------------------------
package dss_pkg;

   localparam int RUN_W    = 9;
   localparam int SUM_W    = 20;
   localparam int SCNT_W   = 20;
   localparam int LCNT_W   = 11;
   localparam int FRAC_W   = 8;
   localparam int AVG_W    = 17;
   localparam int DVD_W    = SUM_W + FRAC_W;
   localparam int DVS_W    = SCNT_W;
   localparam int DCNT_W   = $clog2(DVD_W + 1);

   localparam logic [AVG_W-1:0] AVG_MAX = 17'd94207;

   // Opcodes carried in req_tuser.
   localparam logic [1:0] OP_SAMPLE   = 2'd0;
   localparam logic [1:0] OP_YEAR_END = 2'd1;
   localparam logic [1:0] OP_REPORT   = 2'd2;
   localparam logic [1:0] OP_UNUSED   = 2'd3;

   // One pixel's statistics, as held in one word of the store.
   typedef struct packed {
      logic [RUN_W-1:0]  current_run;
      logic [RUN_W-1:0]  year_longest;
      logic [SUM_W-1:0]  spell_sum;
      logic [SCNT_W-1:0] spell_count;
      logic [SUM_W-1:0]  longest_sum;
      logic [LCNT_W-1:0] longest_count;
   } entry_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

endpackage

/* rtl/dry_spell_statistics.sv */
// ----------------------------------------------------------------------------
// dry_spell_statistics: per-pixel dry spell statistics over rainfall samples
// Keeps run, yearly maximum, sums and counts per pixel in one memory and
// reports fixed-point averages of spell length and yearly longest spell.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake              Contents
//  req      in         req_tvalid/req_tready  opcode in tuser, pixel and rain
//  rsp      out        rsp_tvalid/rsp_tready  pixel and two averages
//  csr      in         csr_valid/csr_ready    dry threshold write
//
// In a sample or year-end transaction the accept cycle issues the memory read,
// and the next cycle updates the entry and writes it back before the next
// request is taken. A report's result comes from the bit-serial divider (28
// quotient bits) and is loaded into the output register from the respond
// state; no new request is taken until then.
// After reset the memory is cleared one entry a cycle, DEPTH entries (at most
// 4096), and no request is taken until then; threshold writes are always taken.
// A report that meets a full output register waits there; other transactions
// still flow past a result that is not yet taken.
// ----------------------------------------------------------------------------
module dry_spell_statistics #(
   parameter int PIXELS  = 4096,
   parameter int MAX_RUN = 366
) (
   input  logic        clock,
   input  logic        reset,
   // Request stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // pixel_index[11:0], rain_amount[27:12], zero[31:28]
   input  logic [1:0]  req_tuser,   // opcode[1:0]
   // Response stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // report_pixel[11:0], avg_spell[28:12],
                                    // avg_longest[45:29], zero[47:46]
   // Threshold register write.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data     // dry_threshold[15:0]
);
   import dss_pkg::*;

   // Entries beyond the reachable pixel index range would never be touched.
   localparam int DEPTH  = (PIXELS < 4096) ? PIXELS : 4096;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PX_W   = 12;
   localparam int RAIN_W = 16;
   localparam int CMP_W  = 21;
   localparam logic [RAIN_W-1:0] THRESH_RESET = 16'd20;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_READ    = 4'b0010,
      ST_DIVIDE  = 4'b0100,
      ST_RESPOND = 4'b1000
   } state_type;

   state_type         state_ff;
   state_type         state_in;
   logic [RAIN_W-1:0] thresh_ff;
   logic [1:0]        op_ff;
   logic [PX_W-1:0]   px_ff;
   logic [RAIN_W-1:0] rain_ff;
   logic              spell_zero_ff;
   logic              longest_zero_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [AVG_W-1:0]  avg_spell_ff;
   logic [AVG_W-1:0]  avg_longest_ff;
   logic [PX_W-1:0]   rsp_px_ff;

   logic [PX_W-1:0]   req_px;
   logic [RAIN_W-1:0] req_rain;
   logic              req_accept;
   logic              px_ok;
   logic              op_known;
   logic              clearing;
   logic              rsp_load;

   entry_type         rd_entry;
   entry_type         wr_entry;
   logic              wr_en;

   div_req_type       div_spell_req;
   div_req_type       div_longest_req;
   logic              div_spell_busy;
   logic              div_longest_busy;
   logic [DVD_W-1:0]  q_spell;
   logic [DVD_W-1:0]  q_longest;
   logic [AVG_W-1:0]  avg_spell;
   logic [AVG_W-1:0]  avg_longest;

   logic [RUN_W-1:0]  run_next;
   logic [SUM_W:0]    spell_sum_wide;
   logic [SUM_W:0]    longest_sum_wide;

   assign req_px     = req_tdata[PX_W-1:0];
   assign req_rain   = req_tdata[PX_W+RAIN_W-1:PX_W];
   assign req_tready = (state_ff == ST_IDLE) && !clearing;
   assign req_accept = req_tvalid && req_tready;
   assign px_ok      = CMP_W'(req_px) < CMP_W'(PIXELS);
   assign op_known   = req_tuser != OP_UNUSED;

   // The threshold register takes a write in any cycle.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else if (csr_valid) begin
         thresh_ff <= csr_data;
      end
   end

   dss_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_accept),
      .rd_addr  (req_px[ADDR_W-1:0]),
      .rd_data  (rd_entry),
      .wr_en    (wr_en),
      .wr_addr  (px_ff[ADDR_W-1:0]),
      .wr_data  (wr_entry),
      .clearing (clearing)
   );

   // Read-modify-write of the entry in the cycle after the read was issued.
   // The state machine keeps the next read behind this write, so the same
   // entry is never read while its update is in flight.
   always_comb begin
      wr_entry         = rd_entry;
      wr_en            = 1'b0;
      run_next         = rd_entry.current_run;
      spell_sum_wide   = {1'b0, rd_entry.spell_sum} + (SUM_W + 1)'(rd_entry.current_run);
      longest_sum_wide = {1'b0, rd_entry.longest_sum} + (SUM_W + 1)'(rd_entry.year_longest);
      if (state_ff == ST_READ) begin
         case (op_ff)
            OP_SAMPLE: begin
               wr_en = 1'b1;
               if (rain_ff < thresh_ff) begin
                  if (rd_entry.current_run < RUN_W'(MAX_RUN)) begin
                     run_next = rd_entry.current_run + 1'b1;
                  end
               end else if (rain_ff > thresh_ff) begin
                  // A wet day closes the run, even one of length zero.
                  wr_entry.spell_sum = spell_sum_wide[SUM_W] ? '1
                                                             : spell_sum_wide[SUM_W-1:0];
                  if (rd_entry.spell_count != '1) begin
                     wr_entry.spell_count = rd_entry.spell_count + 1'b1;
                  end
                  run_next = '0;
               end
               wr_entry.current_run = run_next;
               if (run_next > rd_entry.year_longest) begin
                  wr_entry.year_longest = run_next;
               end
            end
            OP_YEAR_END: begin
               wr_en = 1'b1;
               // An open run is dropped, not counted as a spell.
               if (rd_entry.year_longest != '0) begin
                  wr_entry.longest_sum = longest_sum_wide[SUM_W] ? '1
                                                                 : longest_sum_wide[SUM_W-1:0];
                  if (rd_entry.longest_count != '1) begin
                     wr_entry.longest_count = rd_entry.longest_count + 1'b1;
                  end
               end
               wr_entry.current_run  = '0;
               wr_entry.year_longest = '0;
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end
   end

   // Both averages are divided at once, sum times 256 over count.
   always_comb begin
      div_spell_req.start      = (state_ff == ST_READ) && (op_ff == OP_REPORT);
      div_spell_req.dividend   = {rd_entry.spell_sum, FRAC_W'(0)};
      div_spell_req.divisor    = rd_entry.spell_count;
      div_longest_req.start    = div_spell_req.start;
      div_longest_req.dividend = {rd_entry.longest_sum, FRAC_W'(0)};
      div_longest_req.divisor  = DVS_W'(rd_entry.longest_count);
   end

   dss_divider u_div_spell (
      .clock    (clock),
      .reset    (reset),
      .req      (div_spell_req),
      .busy     (div_spell_busy),
      .quotient (q_spell)
   );

   dss_divider u_div_longest (
      .clock    (clock),
      .reset    (reset),
      .req      (div_longest_req),
      .busy     (div_longest_busy),
      .quotient (q_longest)
   );

   // A zero sum or count reads as a zero average; large quotients clamp.
   always_comb begin
      if (spell_zero_ff) begin
         avg_spell = '0;
      end else if (q_spell > DVD_W'(AVG_MAX)) begin
         avg_spell = AVG_MAX;
      end else begin
         avg_spell = q_spell[AVG_W-1:0];
      end
      if (longest_zero_ff) begin
         avg_longest = '0;
      end else if (q_longest > DVD_W'(AVG_MAX)) begin
         avg_longest = AVG_MAX;
      end else begin
         avg_longest = q_longest[AVG_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // Unknown opcodes and pixels out of range are taken and dropped.
            if (req_accept && px_ok && op_known) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = (op_ff == OP_REPORT) ? ST_DIVIDE : ST_IDLE;
         end
         ST_DIVIDE: begin
            if (!div_spell_busy && !div_longest_busy) begin
               state_in = ST_RESPOND;
            end
         end
         ST_RESPOND: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff   <= req_tuser;
         px_ff   <= req_px;
         rain_ff <= req_rain;
      end
      if (div_spell_req.start) begin
         spell_zero_ff   <= (rd_entry.spell_sum == '0) || (rd_entry.spell_count == '0);
         longest_zero_ff <= (rd_entry.longest_sum == '0) || (rd_entry.longest_count == '0);
      end
      if (rsp_load) begin
         rsp_px_ff      <= px_ff;
         avg_spell_ff   <= avg_spell;
         avg_longest_ff <= avg_longest;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, avg_longest_ff, avg_spell_ff, rsp_px_ff};

   // The update cycle always follows an accepted request.
   a_read_after_accept : assert property (
      @(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> $past(req_tvalid && req_tready)
   ) else $error("entry update without an accepted request");

   // The dividers run only while the state machine waits for them.
   a_div_in_divide : assert property (
      @(posedge clock) disable iff (reset)
      (div_spell_busy || div_longest_busy) |-> (state_ff == ST_DIVIDE)
   ) else $error("divider busy outside the divide state");

   // A new result shows up only out of the respond state.
   a_rsp_from_respond : assert property (
      @(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_RESPOND)
   ) else $error("response raised outside the respond state");

   // No request is taken while the memory is being cleared.
   a_no_accept_clearing : assert property (
      @(posedge clock) disable iff (reset)
      clearing |-> !(state_ff == ST_READ) && !req_tready
   ) else $error("request activity during the clearing pass");

endmodule

/* rtl/dss_store.sv */
// ----------------------------------------------------------------------------
// dss_store: per-pixel statistics memory
// One write port, one read port with registered data, and a clearing pass
// that writes every entry to zero after reset.
// ----------------------------------------------------------------------------
module dss_store #(
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output dss_pkg::entry_type  rd_data,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  dss_pkg::entry_type  wr_data,
   output logic                clearing
);
   import dss_pkg::*;

   entry_type         mem [DEPTH];
   entry_type         rd_data_ff;
   logic              clearing_ff;
   logic              clearing_in;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic [ADDR_W-1:0] clr_addr_in;

   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clearing_ff;

endmodule

/* rtl/dss_divider.sv */
// ----------------------------------------------------------------------------
// dss_divider: radix-2 restoring divider
// Produces one quotient bit per cycle; busy stays high until the last bit.
// ----------------------------------------------------------------------------
module dss_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  dss_pkg::div_req_type       req,
   output logic                       busy,
   output logic [dss_pkg::DVD_W-1:0]  quotient
);
   import dss_pkg::*;

   logic              busy_ff;
   logic              busy_in;
   logic [DCNT_W-1:0] cnt_ff;
   logic [DCNT_W-1:0] cnt_in;
   logic [DVS_W-1:0]  rem_ff;
   logic [DVS_W-1:0]  rem_in;
   logic [DVD_W-1:0]  quo_ff;
   logic [DVD_W-1:0]  quo_in;
   logic [DVS_W-1:0]  dvs_ff;
   logic [DVS_W-1:0]  dvs_in;
   logic [DVS_W:0]    shifted;
   logic              fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[DVD_W-1]};
      fits    = shifted >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = DCNT_W'(DVD_W);
         rem_in  = '0;
         quo_in  = req.dividend;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         // The remainder stays below the divisor, so the difference fits.
         rem_in  = fits ? DVS_W'(shifted - {1'b0, dvs_ff}) : shifted[DVS_W-1:0];
         quo_in  = {quo_ff[DVD_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = cnt_ff != DCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the dry spell statistics block
// Drives sample, year-end, report and unused-opcode transactions with bursty
// timing, stalls the response side, keeps its own per-pixel statistics and
// compares every report field by field against the predicted averages.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import dss_pkg::*;

   localparam int PIXELS  = 4096;
   localparam int MAX_RUN = 366;

   localparam logic [15:0] THRESHOLD_AT_RESET = 16'd20;
   localparam logic [SUM_W-1:0]  SUM_FULL  = '1;
   localparam logic [SCNT_W-1:0] SCNT_FULL = '1;
   localparam logic [LCNT_W-1:0] LCNT_FULL = '1;

   // Idle cycles waited after the last report has arrived, so that nothing is
   // still in flight in the block.
   localparam int SETTLE_CYCLES = 60;
   localparam int MAX_SHOWN     = 10;

   // One report as seen on the response stream.
   typedef struct {
      logic [11:0]      pixel;
      logic [AVG_W-1:0] avg_spell;
      logic [AVG_W-1:0] avg_longest;
   } report_type;

   // -------------------------------------------------------------------------
   // Scoreboard: a private copy of every pixel's statistics plus the queue of
   // reports that the block still owes us.
   // -------------------------------------------------------------------------
   class dry_spell_board;
      bit [15:0]       threshold = THRESHOLD_AT_RESET;
      bit [RUN_W-1:0]  run_len       [PIXELS];
      bit [RUN_W-1:0]  year_max      [PIXELS];
      bit [SUM_W-1:0]  spell_total   [PIXELS];
      bit [SCNT_W-1:0] spell_num     [PIXELS];
      bit [SUM_W-1:0]  longest_total [PIXELS];
      bit [LCNT_W-1:0] longest_num   [PIXELS];
      report_type      pending[$];
      int              failures = 0;

      // Mean in fixed point with 8 fraction bits, truncated, clipped to the output range.
      function automatic logic [AVG_W-1:0] mean_fixed(bit [SUM_W-1:0] total,
                                                      bit [SCNT_W-1:0] num);
         bit [SUM_W+FRAC_W-1:0] quotient;
         if (total == 0 || num == 0) return '0;
         quotient = {total, {FRAC_W{1'b0}}} / num;
         if (quotient > AVG_MAX) return AVG_MAX;
         return quotient[AVG_W-1:0];
      endfunction

      // Applies one accepted request to the predicted state.
      function void note_request(logic [1:0] op, logic [11:0] px, logic [15:0] rain);
         report_type due;
         case (op)
            OP_SAMPLE: begin
               if (rain < threshold) begin
                  if (run_len[px] < MAX_RUN) run_len[px]++;
               end else if (rain > threshold) begin
                  // A wet day closes the spell, even one of length zero.
                  if (spell_total[px] > SUM_FULL - run_len[px])
                     spell_total[px] = SUM_FULL;
                  else
                     spell_total[px] = spell_total[px] + run_len[px];
                  if (spell_num[px] != SCNT_FULL) spell_num[px]++;
                  run_len[px] = '0;
               end
               if (run_len[px] > year_max[px]) year_max[px] = run_len[px];
            end
            OP_YEAR_END: begin
               if (year_max[px] != 0) begin
                  if (longest_total[px] > SUM_FULL - year_max[px])
                     longest_total[px] = SUM_FULL;
                  else
                     longest_total[px] = longest_total[px] + year_max[px];
                  if (longest_num[px] != LCNT_FULL) longest_num[px]++;
               end
               run_len[px]  = '0;
               year_max[px] = '0;
            end
            OP_REPORT: begin
               due.pixel       = px;
               due.avg_spell   = mean_fixed(spell_total[px], spell_num[px]);
               due.avg_longest = mean_fixed(longest_total[px],
                                            {{(SCNT_W-LCNT_W){1'b0}}, longest_num[px]});
               pending.push_back(due);
            end
            default: ;  // The unused opcode leaves everything alone.
         endcase
      endfunction

      // Compares one accepted response with the oldest report still owed.
      function void check_report(logic [47:0] data);
         report_type due;
         if (pending.size() == 0) begin
            failures++;
            if (failures <= MAX_SHOWN)
               $display("unexpected response: pixel %0d spell %0d longest %0d",
                        data[11:0], data[28:12], data[45:29]);
            return;
         end
         due = pending.pop_front();
         if (data[11:0] !== due.pixel || data[28:12] !== due.avg_spell ||
             data[45:29] !== due.avg_longest || data[47:46] !== 2'b00) begin
            failures++;
            if (failures <= MAX_SHOWN)
               $display({"report mismatch: expected pixel %0d spell %0d longest %0d,",
                         " got pixel %0d spell %0d longest %0d pad %b"},
                        due.pixel, due.avg_spell, due.avg_longest,
                        data[11:0], data[28:12], data[45:29], data[47:46]);
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals. Every input of the block has a known value from time zero.
   // -------------------------------------------------------------------------
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;    // pixel_index[11:0], rain_amount[27:12], zero[31:28]
   logic [1:0]  req_tuser  = '0;    // opcode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;          // report_pixel[11:0], avg_spell[28:12],
                                    // avg_longest[45:29], zero[47:46]
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data   = '0;    // dry_threshold[15:0]

   dry_spell_board board;

   // Sender burst state: transactions left in the current burst.
   int          burst_left = 0;
   // Pixels that the random traffic keeps returning to, so statistics build up.
   logic [11:0] pool [8];

   dry_spell_statistics #(
      .PIXELS  (PIXELS),
      .MAX_RUN (MAX_RUN)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // The run is cut off here if the block hangs. A correct run needs well
   // under a tenth of this, clearing pass after reset included.
   initial begin
      #10ms;
      $display("status: fail");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Response side. Ready follows a pattern that changes mode at random intervals:
   // always ready, a rotating bit pattern, or mostly stalled.
   // -------------------------------------------------------------------------
   int          stall_mode  = 0;
   int          stall_left  = 0;
   logic [15:0] stall_bits  = 16'hA5C3;

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(20, 120);
         stall_bits = 16'($urandom);
      end
      stall_left = stall_left - 1;
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1: begin
            rsp_tready <= stall_bits[0];
            stall_bits = {stall_bits[0], stall_bits[15:1]};
         end
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // Every accepted response is checked at the edge that takes it.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_report(rsp_tdata);
   end

   // -------------------------------------------------------------------------
   // Request side.
   // -------------------------------------------------------------------------

   // Sends one request transaction. Between bursts of random length the valid
   // line drops for a random gap; some bursts follow each other directly.
   task automatic send_req(input logic [1:0] op, input logic [11:0] px,
                           input logic [15:0] rain);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left = burst_left - 1;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0000, rain, px};
      do @(posedge clock); while (!req_tready);
      board.note_request(op, px, rain);
   endtask

   // Drops valid and holds off until every owed report has arrived and the
   // block has had time to finish any sample still in its pipeline.
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the dry threshold; only called while the block is idle.
   task automatic write_threshold(input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      board.threshold = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Picks a rainfall value relative to the current threshold: dry with the
   // given percentage, sometimes exactly equal, sometimes any 16-bit value.
   function automatic logic [15:0] pick_rain(input int dry_pct);
      int thr;
      int roll;
      thr  = board.threshold;
      roll = $urandom_range(0, 99);
      if (roll < 10) return 16'($urandom);
      if (roll < 16) return 16'(thr);
      if (roll < 16 + dry_pct && thr != 0) return 16'($urandom_range(0, thr - 1));
      if (thr != 65535) return 16'($urandom_range(thr + 1, 65535));
      return 16'(thr);
   endfunction

   // Random traffic for one phase. Most of it is whole seasons on a pooled
   // pixel (a run of samples, usually a year end, often a report); the rest
   // is lone reports and noise with random opcodes and pixels.
   task automatic random_traffic(input int quota, input bit mid_drain);
      int          sent;
      int          kind;
      int          days;
      int          dry_pct;
      bit          drained;
      logic [11:0] px;
      sent    = 0;
      drained = 1'b0;
      while (sent < quota) begin
         kind = $urandom_range(0, 99);
         px   = pool[3'($urandom_range(0, 7))];
         if (kind < 65) begin
            days    = $urandom_range(3, 30);
            dry_pct = $urandom_range(30, 95);
            repeat (days) send_req(OP_SAMPLE, px, pick_rain(dry_pct));
            sent = sent + days;
            if ($urandom_range(0, 3) != 0) begin
               send_req(OP_YEAR_END, px, 16'($urandom));
               sent++;
            end
            if ($urandom_range(0, 1) == 1) begin
               send_req(OP_REPORT, px, 16'($urandom));
               sent++;
            end
         end else if (kind < 85) begin
            send_req(OP_REPORT, px, 16'($urandom));
            sent++;
         end else begin
            send_req(2'($urandom_range(0, 3)), 12'($urandom), 16'($urandom));
            sent++;
         end
         // Hold the sender back once until every owed report is in.
         if (mid_drain && !drained && sent >= quota / 2) begin
            settle();
            drained = 1'b1;
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence.
   // -------------------------------------------------------------------------
   initial begin
      logic [11:0] px;
      board = new;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset threshold. The first request waits for
      // the clearing pass after reset through the handshake.
      // Dry at zero rain, no change at the threshold, wet at full scale.
      send_req(OP_SAMPLE,   12'd0, 16'd0);
      send_req(OP_SAMPLE,   12'd0, THRESHOLD_AT_RESET);
      send_req(OP_SAMPLE,   12'd0, 16'hFFFF);
      send_req(OP_REPORT,   12'd0, 16'hFFFF);
      send_req(OP_YEAR_END, 12'd0, 16'h0000);
      send_req(OP_REPORT,   12'd0, 16'h5A5A);
      // Unused opcode must leave the pixel as it was.
      send_req(OP_UNUSED,   12'd0, 16'd0);
      send_req(OP_REPORT,   12'd0, 16'd0);
      // Zero-length spell: the sum stays zero, so the average is zero.
      send_req(OP_SAMPLE,   12'hFFF, 16'd21);
      send_req(OP_REPORT,   12'hFFF, 16'hA5A5);
      // Year end with no dry day is not counted: zero over zero.
      send_req(OP_YEAR_END, 12'hFFF, 16'hFFFF);
      send_req(OP_REPORT,   12'hFFF, 16'd0);
      send_req(OP_UNUSED,   12'd5, 16'hFFFF);
      send_req(OP_REPORT,   12'd5, 16'd0);
      // An open run at year end is dropped, not added to the spell sum.
      send_req(OP_SAMPLE,   12'd7, 16'd19);
      send_req(OP_SAMPLE,   12'd7, 16'd3);
      send_req(OP_YEAR_END, 12'd7, 16'd0);
      send_req(OP_SAMPLE,   12'd7, 16'd500);
      send_req(OP_REPORT,   12'd7, 16'd0);
      // A pixel never touched since reset.
      send_req(OP_REPORT,   12'd2048, 16'hFFFF);

      // Random phases, each at its own threshold. The first runs at the reset
      // value; the others start with a write once the block is idle.
      for (int phase = 0; phase < 5; phase++) begin
         for (int i = 0; i < 8; i++) pool[3'(i)] = 12'($urandom);
         pool[0] = 12'd0;
         pool[1] = 12'hFFF;
         if (phase > 0) begin
            settle();
            case (phase)
               1:       write_threshold(16'd0);
               2:       write_threshold(16'hFFFF);
               3:       write_threshold(16'($urandom));
               default: write_threshold(16'($urandom_range(1, 200)));
            endcase
         end
         random_traffic(80, phase == 3);
         // A drought longer than the run limit, so the run saturates; then
         // the spell is closed and the year ended.
         if (phase == 4) begin
            px = pool[2];
            repeat (380) send_req(OP_SAMPLE, px,
                                  16'($urandom_range(0, board.threshold - 1)));
            send_req(OP_SAMPLE,   px, 16'hFFFF);
            send_req(OP_REPORT,   px, 16'd0);
            send_req(OP_YEAR_END, px, 16'd0);
            send_req(OP_REPORT,   px, 16'd0);
         end
      end

      // Let the last reports arrive, then give the block time to go quiet.
      settle();
      if (board.failures == 0 && board.pending.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/dss_pkg.sv
rtl/dss_store.sv
rtl/dss_divider.sv
rtl/dry_spell_statistics.sv
tb/testbench.sv
